// File: rtl/mm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply package
// Shared widths, register indexes and the command that travels from the
// front end to the multiply engine.
// ----------------------------------------------------------------------------
package mm_pkg;

    // Field widths fixed by the interface.
    localparam int DIM_W      = 4;
    localparam int IDX_FIELD_W = 3;
    localparam int VALUE_W    = 32;
    localparam int REG_IDX_W  = 2;

    // Largest supported sizes; parameters on the top level may be smaller.
    localparam int MAX_DIM_DEFAULT    = 8;
    localparam int WORD_WIDTH_DEFAULT = 32;
    localparam int ADDR_MAX_W         = 6;
    localparam int FRAC_BITS          = 16;
    localparam int QUEUE_DEPTH        = 4;

    // Dimension registers come out of reset at the largest size.
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    // Matrix dimensions as programmed.
    typedef struct packed {
        logic [DIM_W-1:0] rows_a;
        logic [DIM_W-1:0] inner_dim;
        logic [DIM_W-1:0] cols_b;
    } dims_t;

    // One classified load, possibly carrying the start of a multiply.
    typedef struct packed {
        logic                  wr;
        logic                  is_b;
        logic [ADDR_MAX_W-1:0] addr;
        logic [VALUE_W-1:0]    value;
        logic                  start;
    } cmd_t;

endpackage

// File: rtl/mm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply front end
// Accepts element transactions, checks the element index, forms the store
// address and registers the resulting command towards the queue.
// ----------------------------------------------------------------------------
module mm_front #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_is_b,
    input  logic [mm_pkg::IDX_FIELD_W-1:0]   s_elem_row,
    input  logic [mm_pkg::IDX_FIELD_W-1:0]   s_elem_col,
    input  logic signed [mm_pkg::VALUE_W-1:0] s_elem_value,
    input  logic                             s_start_req,
    output logic                             cmd_valid,
    input  logic                             cmd_ready,
    output mm_pkg::cmd_t                     cmd
);
    import mm_pkg::*;

    localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

    logic        valid_reg, valid_next;
    cmd_t        cmd_reg, cmd_next;
    logic        in_range;
    logic [ADDR_W-1:0] addr;
    logic        accept;

    // Classify the incoming transaction.
    always_comb begin
        in_range = (int'(s_elem_row) < MAX_DIM) && (int'(s_elem_col) < MAX_DIM);
        addr     = ADDR_W'(s_elem_row) * ADDR_W'(MAX_DIM) + ADDR_W'(s_elem_col);
        s_ready  = !valid_reg || cmd_ready;
        accept   = s_valid && s_ready;

        cmd_next       = cmd_reg;
        cmd_next.wr    = in_range;
        cmd_next.is_b  = s_is_b;
        cmd_next.addr  = ADDR_MAX_W'(addr);
        cmd_next.value = s_elem_value;
        cmd_next.start = s_start_req;

        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (cmd_ready) begin
            valid_next = 1'b0;
        end
    end

    // Command register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (accept) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

// File: rtl/mm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply command queue
// Short first-in first-out queue that lets the front end keep taking loads
// while the engine is busy with a multiply.
// ----------------------------------------------------------------------------
module mm_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push_valid,
    output logic         push_ready,
    input  mm_pkg::cmd_t push_cmd,
    output logic         pop_valid,
    input  logic         pop_ready,
    output mm_pkg::cmd_t pop_cmd
);
    import mm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]    count_reg, count_next;
    logic              do_push, do_pop;

    // Pointer and fill level bookkeeping.
    always_comb begin
        push_ready  = (int'(count_reg) < QUEUE_DEPTH);
        pop_valid   = (count_reg != '0);
        do_push     = push_valid && push_ready;
        do_pop      = pop_valid && pop_ready;
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (PTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign pop_cmd = entry_reg[rd_ptr_reg];

endmodule

// File: rtl/mm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply engine
// Holds the A and B stores, performs loads, and on a start walks the result
// matrix row-major through a read, multiply, accumulate, round-and-saturate
// pipeline, one multiply-accumulate per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module mm_back #(
    parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEFAULT,
    parameter int WORD_WIDTH = mm_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  mm_pkg::cmd_t                      cmd,
    input  mm_pkg::dims_t                     dims,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mm_pkg::IDX_FIELD_W-1:0]    m_out_row,
    output logic [mm_pkg::IDX_FIELD_W-1:0]    m_out_col,
    output logic signed [mm_pkg::VALUE_W-1:0] m_out_value,
    output logic                              m_saturated,
    output logic                              m_last
);
    import mm_pkg::*;

    localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int PROD_W = 2 * WORD_WIDTH;
    localparam int ACC_W  = PROD_W + IDX_W + 1;
    localparam int SH_W   = ACC_W - FRAC_BITS;
    localparam logic [DIM_W-1:0] MAX_D = DIM_W'(MAX_DIM);
    localparam logic signed [SH_W-1:0] SAT_MAX =
        {{(SH_W-WORD_WIDTH+1){1'b0}}, {(WORD_WIDTH-1){1'b1}}};
    localparam logic signed [SH_W-1:0] SAT_MIN =
        {{(SH_W-WORD_WIDTH+1){1'b1}}, {(WORD_WIDTH-1){1'b0}}};

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    // Element stores.
    logic signed [WORD_WIDTH-1:0] a_mem [DEPTH];
    logic signed [WORD_WIDTH-1:0] b_mem [DEPTH];

    // Sequencer.
    state_t           state_reg, state_next;
    logic [DIM_W-1:0] nr_reg, nr_next, nk_reg, nk_next, nc_reg, nc_next;
    logic             nk_zero_reg, nk_zero_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [DIM_W-1:0] eff_r, eff_k, eff_c;
    logic             adv, cmd_pop, k_last, j_last, i_last, running;
    logic [ADDR_W-1:0] a_raddr, b_raddr, waddr;

    // Pipeline stages.
    logic signed [WORD_WIDTH-1:0] a_rd_reg, b_rd_reg;
    logic             s1_valid_reg, s1_first_reg, s1_last_reg, s1_zero_reg, s1_end_reg;
    logic [IDX_W-1:0] s1_row_reg, s1_col_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic             s2_valid_reg, s2_first_reg, s2_last_reg, s2_end_reg;
    logic [IDX_W-1:0] s2_row_reg, s2_col_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_base, acc_next;
    logic             s3_valid_reg, s3_end_reg;
    logic [IDX_W-1:0] s3_row_reg, s3_col_reg;

    // Rounding and saturation.
    logic signed [SH_W-1:0]       shifted;
    logic                         sat_hi, sat_lo;
    logic signed [WORD_WIDTH-1:0] word;

    // Output register.
    logic                       m_valid_reg;
    logic [IDX_FIELD_W-1:0]     m_row_reg, m_col_reg;
    logic signed [VALUE_W-1:0]  m_value_reg;
    logic                       m_sat_reg, m_last_reg;

    // Sequencer next state and store addresses.
    always_comb begin
        adv       = !m_valid_reg || m_ready;
        running   = (state_reg == ST_RUN);
        cmd_ready = (state_reg == ST_IDLE);
        cmd_pop   = cmd_valid && cmd_ready;

        eff_r = (dims.rows_a > MAX_D) ? MAX_D : dims.rows_a;
        eff_k = (dims.inner_dim > MAX_D) ? MAX_D : dims.inner_dim;
        eff_c = (dims.cols_b > MAX_D) ? MAX_D : dims.cols_b;

        k_last = nk_zero_reg || (DIM_W'(k_reg) + DIM_W'(1) == nk_reg);
        j_last = (DIM_W'(j_reg) + DIM_W'(1) == nc_reg);
        i_last = (DIM_W'(i_reg) + DIM_W'(1) == nr_reg);

        a_raddr = ADDR_W'(i_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(k_reg);
        b_raddr = ADDR_W'(k_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(j_reg);
        waddr   = cmd.addr[ADDR_W-1:0];

        state_next   = state_reg;
        nr_next      = nr_reg;
        nk_next      = nk_reg;
        nc_next      = nc_reg;
        nk_zero_next = nk_zero_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_pop && cmd.start && (eff_r != '0) && (eff_c != '0)) begin
                    state_next   = ST_RUN;
                    nr_next      = eff_r;
                    nk_next      = eff_k;
                    nc_next      = eff_c;
                    nk_zero_next = (eff_k == '0);
                    i_next       = '0;
                    j_next       = '0;
                    k_next       = '0;
                end
            end
            ST_RUN: begin
                if (adv) begin
                    if (!k_last) begin
                        k_next = k_reg + IDX_W'(1);
                    end else begin
                        k_next = '0;
                        if (!j_last) begin
                            j_next = j_reg + IDX_W'(1);
                        end else begin
                            j_next = '0;
                            if (i_last) begin
                                state_next = ST_IDLE;
                            end else begin
                                i_next = i_reg + IDX_W'(1);
                            end
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Store writes and registered reads.
    always_ff @(posedge aclk) begin
        if (cmd_pop && cmd.wr) begin
            if (cmd.is_b) begin
                b_mem[waddr] <= cmd.value[WORD_WIDTH-1:0];
            end else begin
                a_mem[waddr] <= cmd.value[WORD_WIDTH-1:0];
            end
        end
        if (adv) begin
            a_rd_reg <= a_mem[a_raddr];
            b_rd_reg <= b_mem[b_raddr];
        end
    end

    // Accumulate, then floor to Q16.16 and clip to the word range.
    always_comb begin
        acc_base = s2_first_reg ? ACC_W'(0) : acc_reg;
        acc_next = acc_base + ACC_W'(prod_reg);
        shifted  = SH_W'(acc_reg >>> FRAC_BITS);
        sat_hi   = (shifted > SAT_MAX);
        sat_lo   = (shifted < SAT_MIN);
        if (sat_hi) begin
            word = SAT_MAX[WORD_WIDTH-1:0];
        end else if (sat_lo) begin
            word = SAT_MIN[WORD_WIDTH-1:0];
        end else begin
            word = shifted[WORD_WIDTH-1:0];
        end
    end

    // Sequencer state, pipeline stages and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            nk_zero_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            nk_zero_reg <= nk_zero_next;
            if (adv) begin
                s1_valid_reg <= running;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg && s2_last_reg;
                m_valid_reg  <= s3_valid_reg;
            end
        end

        nr_reg <= nr_next;
        nk_reg <= nk_next;
        nc_reg <= nc_next;
        i_reg  <= i_next;
        j_reg  <= j_next;
        k_reg  <= k_next;

        if (adv) begin
            s1_first_reg <= (k_reg == '0);
            s1_last_reg  <= k_last;
            s1_zero_reg  <= nk_zero_reg;
            s1_end_reg   <= i_last && j_last;
            s1_row_reg   <= i_reg;
            s1_col_reg   <= j_reg;

            prod_reg     <= s1_zero_reg ? PROD_W'(0) : a_rd_reg * b_rd_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s2_end_reg   <= s1_end_reg;
            s2_row_reg   <= s1_row_reg;
            s2_col_reg   <= s1_col_reg;

            if (s2_valid_reg) begin
                acc_reg <= acc_next;
            end
            s3_end_reg <= s2_end_reg;
            s3_row_reg <= s2_row_reg;
            s3_col_reg <= s2_col_reg;

            m_row_reg   <= IDX_FIELD_W'(s3_row_reg);
            m_col_reg   <= IDX_FIELD_W'(s3_col_reg);
            m_value_reg <= VALUE_W'(word);
            m_sat_reg   <= sat_hi || sat_lo;
            m_last_reg  <= s3_end_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_row   = m_row_reg;
    assign m_out_col   = m_col_reg;
    assign m_out_value = m_value_reg;
    assign m_saturated = m_sat_reg;
    assign m_last      = m_last_reg;

endmodule

// File: rtl/matrix_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply
// Q16.16 general matrix multiply with element load port and result stream.
// ----------------------------------------------------------------------------
// Each input transaction loads one element of A or B; loads flow through a
// registered front end and a four-entry queue, and the engine retires one
// load per cycle while it is idle. A transaction with start_req set performs
// its load and then computes C = A x B: the engine issues one
// multiply-accumulate per cycle on its single multiplier while the result
// side does not stall, and takes no load while a multiply runs. Results
// appear in row-major order, the final one flagged with last; stalls on the
// result side hold the whole engine. Dimension registers above MAX_DIM act
// as MAX_DIM. The stores have no reset and need no clearing pass; an element
// must be loaded before a multiply reads it. Dimension registers may be
// written only while idle.
// ----------------------------------------------------------------------------
module matrix_multiply #(
    parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEFAULT,
    parameter int WORD_WIDTH = mm_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mm_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [mm_pkg::DIM_W-1:0]          cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_is_b,
    input  logic [mm_pkg::IDX_FIELD_W-1:0]    s_elem_row,
    input  logic [mm_pkg::IDX_FIELD_W-1:0]    s_elem_col,
    input  logic signed [mm_pkg::VALUE_W-1:0] s_elem_value,
    input  logic                              s_start_req,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mm_pkg::IDX_FIELD_W-1:0]    m_out_row,
    output logic [mm_pkg::IDX_FIELD_W-1:0]    m_out_col,
    output logic signed [mm_pkg::VALUE_W-1:0] m_out_value,
    output logic                              m_saturated,
    output logic                              m_last
);
    import mm_pkg::*;

    dims_t dims_reg, dims_next;
    logic  front_valid, front_ready;
    cmd_t  front_cmd;
    logic  queue_valid, queue_ready;
    cmd_t  queue_cmd;

    // Dimension registers.
    always_comb begin
        dims_next = dims_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_ROWS_A:    dims_next.rows_a    = cfg_wdata;
                REG_INNER_DIM: dims_next.inner_dim = cfg_wdata;
                REG_COLS_B:    dims_next.cols_b    = cfg_wdata;
                default:       dims_next = dims_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg.rows_a    <= DIM_RESET;
            dims_reg.inner_dim <= DIM_RESET;
            dims_reg.cols_b    <= DIM_RESET;
        end else begin
            dims_reg <= dims_next;
        end
    end

    mm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_is_b       (s_is_b),
        .s_elem_row   (s_elem_row),
        .s_elem_col   (s_elem_col),
        .s_elem_value (s_elem_value),
        .s_start_req  (s_start_req),
        .cmd_valid    (front_valid),
        .cmd_ready    (front_ready),
        .cmd          (front_cmd)
    );

    mm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_cmd    (queue_cmd)
    );

    mm_back #(
        .MAX_DIM    (MAX_DIM),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (queue_valid),
        .cmd_ready   (queue_ready),
        .cmd         (queue_cmd),
        .dims        (dims_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_out_value (m_out_value),
        .m_saturated (m_saturated),
        .m_last      (m_last)
    );

endmodule

// File: sim/matrix_multiply_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply testbench
// Loads elements of A and B through the input channel, starts multiplies
// at many sizes and checks every element of C against a built-in model.
// ----------------------------------------------------------------------------
// A directed part covers the value extremes, the rounding toward minus
// infinity, saturation both ways, zero and oversized dimensions. A random
// part then runs phases of random loads and starts with random idling on
// both channels. The model predicts each result matrix when the start
// transaction is accepted; the monitor checks results in order.
// ----------------------------------------------------------------------------
module matrix_multiply_tb;
    import mm_pkg::*;

    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          DRAIN_CYCLES = 32;
    localparam int          RANDOM_ITEMS = 72;
    localparam int          QUIET_FROM   = 52;
    localparam logic        TARGET_A     = 1'b0;
    localparam logic        TARGET_B     = 1'b1;
    localparam logic        NO_START     = 1'b0;
    localparam logic        START        = 1'b1;
    localparam logic signed [79:0] Q_MAX = 80'sd2147483647;
    localparam logic signed [79:0] Q_MIN = -80'sd2147483648;

    // One element load, possibly starting a multiply.
    typedef struct packed {
        logic        is_b;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        start;
    } load_t;

    // One element of the product matrix.
    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        sat;
        logic        last;
    } c_elem_t;

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [REG_IDX_W-1:0]          cfg_index   = '0;
    logic [DIM_W-1:0]              cfg_wdata   = '0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic                          s_is_b      = 1'b0;
    logic [IDX_FIELD_W-1:0]        s_elem_row  = '0;
    logic [IDX_FIELD_W-1:0]        s_elem_col  = '0;
    logic signed [VALUE_W-1:0]     s_elem_value = '0;
    logic                          s_start_req = 1'b0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic [IDX_FIELD_W-1:0]        m_out_row;
    logic [IDX_FIELD_W-1:0]        m_out_col;
    logic signed [VALUE_W-1:0]     m_out_value;
    logic                          m_saturated;
    logic                          m_last;

    // Model state: both stores and the programmed dimensions.
    logic signed [31:0] a_mem [64];
    logic signed [31:0] b_mem [64];
    logic [DIM_W-1:0]   dim_rows  = DIM_RESET;
    logic [DIM_W-1:0]   dim_inner = DIM_RESET;
    logic [DIM_W-1:0]   dim_cols  = DIM_RESET;

    // Stimulus side: pending loads and which entries have been loaded.
    load_t       pend_q [$];
    c_elem_t     expected_c [$];
    bit          a_loaded [64];
    bit          b_loaded [64];
    int          gen_nr = 8;
    int          gen_nk = 8;
    int          gen_nc = 8;
    int          items_queued = 0;

    load_t       cur_load;
    bit          load_taken   = 1'b0;
    bit          quiet        = 1'b0;
    int unsigned gap_odds     = 20;
    int unsigned stall_odds   = 20;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;

    matrix_multiply DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_is_b       (s_is_b),
        .s_elem_row   (s_elem_row),
        .s_elem_col   (s_elem_col),
        .s_elem_value (s_elem_value),
        .s_start_req  (s_start_req),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_out_value  (m_out_value),
        .m_saturated  (m_saturated),
        .m_last       (m_last)
    );

    always #1 aclk = ~aclk;

    // Run limit in case the block hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int eff_dim(logic [DIM_W-1:0] d);
        return (d > 4'd8) ? 8 : int'(d);
    endfunction

    // Applies one accepted load to the model stores and, on a start,
    // queues every element of C: exact dot product, floored to Q16.16,
    // clipped to the 32-bit range.
    function automatic void apply_load(load_t ld);
        int                 nr;
        int                 nk;
        int                 nc;
        logic signed [63:0] av;
        logic signed [63:0] bv;
        logic signed [79:0] acc;
        logic signed [79:0] q;
        c_elem_t            e;
        if (ld.is_b == TARGET_B)
            b_mem[{ld.row, ld.col}] = ld.value;
        else
            a_mem[{ld.row, ld.col}] = ld.value;
        if (ld.start != START)
            return;
        nr = eff_dim(dim_rows);
        nk = eff_dim(dim_inner);
        nc = eff_dim(dim_cols);
        for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
                acc = '0;
                for (int k = 0; k < nk; k++) begin
                    av = a_mem[i * 8 + k];
                    bv = b_mem[k * 8 + j];
                    acc = acc + av * bv;
                end
                q = acc >>> FRAC_BITS;
                e.row  = 3'(i);
                e.col  = 3'(j);
                e.last = (i == nr - 1) && (j == nc - 1);
                if (q > Q_MAX) begin
                    e.value = 32'h7FFF_FFFF;
                    e.sat   = 1'b1;
                end else if (q < Q_MIN) begin
                    e.value = 32'h8000_0000;
                    e.sat   = 1'b1;
                end else begin
                    e.value = q[31:0];
                    e.sat   = 1'b0;
                end
                expected_c.push_back(e);
            end
        end
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Input side: note each accepted transaction and feed it to the model.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            apply_load(cur_load);
            load_taken = 1'b1;
        end
    end

    // Input side: present the next pending load, with random gaps.
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || load_taken)) begin
            load_taken = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < gap_odds) begin
                gap_left = $urandom_range(0, 14);
                s_valid <= 1'b0;
            end else if (pend_q.size() != 0) begin
                cur_load = pend_q.pop_front();
                s_is_b       <= cur_load.is_b;
                s_elem_row   <= cur_load.row;
                s_elem_col   <= cur_load.col;
                s_elem_value <= cur_load.value;
                s_start_req  <= cur_load.start;
                s_valid      <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side: random stalls in bursts.
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < stall_odds) begin
            stall_left = $urandom_range(0, 14);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result side: compare each transaction with the oldest expected element.
    always @(posedge aclk) begin : result_check
        c_elem_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_c.size() == 0) begin
                report_mismatch($sformatf("unexpected result C[%0d][%0d] = %h",
                                          m_out_row, m_out_col, m_out_value));
            end else begin
                want = expected_c.pop_front();
                if (m_out_row !== want.row || m_out_col !== want.col)
                    report_mismatch($sformatf("position got [%0d][%0d] want [%0d][%0d]",
                                              m_out_row, m_out_col, want.row, want.col));
                if (m_out_value !== want.value)
                    report_mismatch($sformatf("C[%0d][%0d] value got %h want %h",
                                              want.row, want.col, m_out_value, want.value));
                if (m_saturated !== want.sat)
                    report_mismatch($sformatf("C[%0d][%0d] saturated got %b want %b",
                                              want.row, want.col, m_saturated, want.sat));
                if (m_last !== want.last)
                    report_mismatch($sformatf("C[%0d][%0d] last got %b want %b",
                                              want.row, want.col, m_last, want.last));
            end
        end
    end

    // Mixes the value extremes, small Q16.16 numbers and full random words.
    function automatic logic [31:0] rand_value();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3, 4, 5: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
            default: return $urandom;
        endcase
    endfunction

    // Random index, mostly inside the active part of the matrix.
    function automatic logic [2:0] pick_index(int lim);
        if (lim == 0 || $urandom_range(0, 4) == 0)
            return 3'($urandom_range(0, 7));
        return 3'($urandom_range(0, lim - 1));
    endfunction

    task automatic push_load(logic is_b, logic [2:0] row, logic [2:0] col,
                             logic [31:0] value, logic start);
        load_t ld;
        ld = '{is_b: is_b, row: row, col: col, value: value, start: start};
        pend_q.push_back(ld);
        if (is_b == TARGET_B)
            b_loaded[{row, col}] = 1'b1;
        else
            a_loaded[{row, col}] = 1'b1;
        items_queued++;
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_ROWS_A:    dim_rows  = val;
            REG_INNER_DIM: dim_inner = val;
            REG_COLS_B:    dim_cols  = val;
            default:       ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_dims(logic [DIM_W-1:0] r, logic [DIM_W-1:0] k,
                            logic [DIM_W-1:0] c);
        write_reg(REG_ROWS_A, r);
        write_reg(REG_INNER_DIM, k);
        write_reg(REG_COLS_B, c);
        gen_nr = eff_dim(r);
        gen_nk = eff_dim(k);
        gen_nc = eff_dim(c);
    endtask

    // Loads any operand the next multiply would read but that was never
    // loaded, so that no store entry is read before it is written.
    task automatic cover_operands();
        if (gen_nr != 0 && gen_nc != 0) begin
            for (int i = 0; i < gen_nr; i++)
                for (int k = 0; k < gen_nk; k++)
                    if (!a_loaded[i * 8 + k])
                        push_load(TARGET_A, 3'(i), 3'(k), rand_value(), NO_START);
            for (int k = 0; k < gen_nk; k++)
                for (int j = 0; j < gen_nc; j++)
                    if (!b_loaded[k * 8 + j])
                        push_load(TARGET_B, 3'(k), 3'(j), rand_value(), NO_START);
        end
    endtask

    task automatic start_multiply();
        logic is_b;
        cover_operands();
        is_b = 1'($urandom_range(0, 1));
        if (is_b == TARGET_B)
            push_load(TARGET_B, pick_index(gen_nk), pick_index(gen_nc), rand_value(), START);
        else
            push_load(TARGET_A, pick_index(gen_nr), pick_index(gen_nk), rand_value(), START);
    endtask

    // Waits until every load is in and every result is out, then lets the
    // engine drain before the dimensions may change.
    task automatic settle();
        while (pend_q.size() != 0 || s_valid || expected_c.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return 4'd0;
        if (pick < 10)
            return 4'($urandom_range(9, 15));
        if (pick < 20)
            return 4'($urandom_range(5, 8));
        return 4'($urandom_range(1, 4));
    endfunction

    function automatic int unsigned pick_odds();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 25;
            default: return 50;
        endcase
    endfunction

    // Stimulus sequence and end of run.
    initial begin
        int base;
        int n_starts;
        int n_loads;
        logic is_b;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Single-element products: saturation both ways, exact halves and
        // the rounding of a tiny negative product toward minus infinity.
        set_dims(4'd1, 4'd1, 4'd1);
        push_load(TARGET_A, 3'd0, 3'd0, 32'h7FFF_FFFF, NO_START);
        push_load(TARGET_B, 3'd0, 3'd0, 32'h7FFF_FFFF, START);
        push_load(TARGET_A, 3'd0, 3'd0, 32'h8000_0000, START);
        push_load(TARGET_B, 3'd0, 3'd0, 32'h8000_0000, START);
        push_load(TARGET_A, 3'd0, 3'd0, 32'h0001_0000, NO_START);
        push_load(TARGET_B, 3'd0, 3'd0, 32'hFFFF_8000, START);
        push_load(TARGET_A, 3'd0, 3'd0, 32'h0000_0001, NO_START);
        push_load(TARGET_B, 3'd0, 3'd0, 32'hFFFF_FFFF, START);
        push_load(TARGET_A, 3'd7, 3'd7, 32'h0000_0000, NO_START);
        push_load(TARGET_B, 3'd7, 3'd0, 32'h7FFF_FFFF, NO_START);
        push_load(TARGET_B, 3'd0, 3'd7, 32'h8000_0000, NO_START);
        settle();

        // Zero rows or zero columns give no result at all.
        set_dims(4'd0, 4'd1, 4'd1);
        push_load(TARGET_A, 3'd0, 3'd0, 32'h0002_0000, START);
        settle();
        set_dims(4'd1, 4'd1, 4'd0);
        push_load(TARGET_B, 3'd0, 3'd0, 32'h0003_0000, START);
        settle();

        // A zero inner dimension gives an all-zero, unsaturated matrix.
        set_dims(4'd2, 4'd0, 4'd3);
        push_load(TARGET_A, 3'd1, 3'd1, 32'h7FFF_FFFF, START);
        settle();

        // Oversized registers act as the full size, one register at a time.
        set_dims(4'd9, 4'd1, 4'd1);
        start_multiply();
        settle();
        set_dims(4'd1, 4'd15, 4'd1);
        start_multiply();
        settle();
        set_dims(4'd1, 4'd1, 4'd12);
        start_multiply();
        settle();

        // Random phases: new sizes, random loads, one or more multiplies.
        base = items_queued;
        while (items_queued - base < RANDOM_ITEMS) begin
            settle();
            quiet = (items_queued - base >= QUIET_FROM);
            gap_odds   = pick_odds();
            stall_odds = pick_odds();
            set_dims(pick_dim(), pick_dim(), pick_dim());
            n_starts = $urandom_range(1, 3);
            for (int s = 0; s < n_starts; s++) begin
                n_loads = $urandom_range(0, 5);
                for (int n = 0; n < n_loads; n++) begin
                    is_b = 1'($urandom_range(0, 1));
                    if (is_b == TARGET_B)
                        push_load(TARGET_B, pick_index(gen_nk), pick_index(gen_nc),
                                  rand_value(), NO_START);
                    else
                        push_load(TARGET_A, pick_index(gen_nr), pick_index(gen_nk),
                                  rand_value(), NO_START);
                end
                // Now and then a burst of stray loads with no multiply.
                if ($urandom_range(0, 7) == 0)
                    for (int n = 0; n < 4; n++)
                        push_load(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                                  3'($urandom_range(0, 7)), $urandom, NO_START);
                start_multiply();
            end
        end
        settle();

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
rtl/mm_pkg.sv
rtl/mm_front.sv
rtl/mm_queue.sv
rtl/mm_back.sv
rtl/matrix_multiply.sv
sim/matrix_multiply_tb.sv
